// ===== rtl/rkd_pkg.sv =====
// Shared types and constants for the RSA key derivation block.
// Used by the interfaces, the remainder unit and the top level; no dependencies.
`default_nettype none
package rkd_pkg;

  localparam int PRIME_W         = 8;
  localparam int WORD_W          = 16;
  localparam int PRIME_LIMIT_DEF = 256;
  localparam int CNT_W           = $clog2(WORD_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_CHECK,
    S_GCD,
    S_GCD_WAIT,
    S_EMOD,
    S_EMOD_WAIT,
    S_DSTEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/rkd_ifs.sv =====
// Handshake channels of the key derivation block: the prime pair in, the key word out.
// Depends on rkd_pkg for the field widths.
`default_nettype none
interface rkd_in_if;
  logic                         valid;
  logic                         ready;
  logic [rkd_pkg::PRIME_W-1:0]  prime_p;
  logic [rkd_pkg::PRIME_W-1:0]  prime_q;

  modport source (output valid, output prime_p, output prime_q, input ready);
  modport sink   (input valid, input prime_p, input prime_q, output ready);
endinterface

interface rkd_out_if;
  logic                        valid;
  logic                        ready;
  logic [rkd_pkg::WORD_W-1:0]  modulus;
  logic [rkd_pkg::WORD_W-1:0]  public_exp;
  logic [rkd_pkg::WORD_W-1:0]  private_exp;
  logic                        bad_input;

  modport source (output valid, output modulus, output public_exp, output private_exp,
                  output bad_input, input ready);
  modport sink   (input valid, input modulus, input public_exp, input private_exp,
                  input bad_input, output ready);
endinterface
`default_nettype wire

// ===== rtl/rkd_mod_unit.sv =====
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on rkd_pkg for the request and response structs.
`default_nettype none
module rkd_mod_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rkd_pkg::mod_req_t req,
  output rkd_pkg::mod_rsp_t      rsp
);

  logic                          busy;
  logic                          done;
  logic [rkd_pkg::CNT_W-1:0]     cnt;
  logic [rkd_pkg::WORD_W-1:0]    rem;
  logic [rkd_pkg::WORD_W-1:0]    rem_next;
  logic [rkd_pkg::WORD_W-1:0]    shreg;
  logic [rkd_pkg::WORD_W-1:0]    divisor;
  logic [rkd_pkg::WORD_W:0]      trial;

  always_comb begin
    trial = {rem, shreg[rkd_pkg::WORD_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = rkd_pkg::WORD_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[rkd_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        shreg   <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= {shreg[rkd_pkg::WORD_W-2:0], 1'b0};
        cnt   <= cnt + 1'b1;
        if (cnt == rkd_pkg::CNT_W'(rkd_pkg::WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// ===== rtl/rsa_key_derivation_top.sv =====
// Top level of the textbook RSA key derivation block: sequencer, datapath, output register.
// Depends on rkd_pkg, the rkd_in_if / rkd_out_if channels and rkd_mod_unit.
//
//   channel  | direction | word
//   ---------+-----------+-------------------------------------------------
//   primes   | in        | prime_p, prime_q
//   keys     | out       | modulus, public_exp, private_exp, bad_input
//
// A rejected pair or one with phi below two skips the searches; otherwise the word waits on
// each remainder call of the gcd search for e and on the candidates d, up to phi + 1.
// The shared remainder unit and the linear search for d set how long a word takes.
// Reset is synchronous and returns the sequencer to idle with no result pending.
// A finished result waits in the output register while the next pair is taken.
`default_nettype none
module rsa_key_derivation_top #(
  parameter int PRIME_LIMIT = rkd_pkg::PRIME_LIMIT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rkd_in_if.sink     primes,
  rkd_out_if.source  keys
);

  localparam int W = rkd_pkg::WORD_W;
  localparam int P = rkd_pkg::PRIME_W;

  rkd_pkg::state_t   state;
  rkd_pkg::state_t   state_next;
  rkd_pkg::mod_req_t mreq;
  rkd_pkg::mod_rsp_t mrsp;

  logic [P-1:0] p;
  logic [P-1:0] q;
  logic [W-1:0] n;
  logic [W-1:0] phi;
  logic         bad;
  logic [W-1:0] e;
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic [W-1:0] em;
  logic [W-1:0] d;
  logic [W-1:0] r;
  logic [W:0]   rsum;
  logic [W-1:0] r_next;
  logic         out_free;

  rkd_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_comb begin
    rsum = {1'b0, r} + {1'b0, em};
    if (rsum >= {1'b0, phi}) begin
      r_next = W'(rsum - {1'b0, phi});
    end else begin
      r_next = rsum[W-1:0];
    end
  end

  assign out_free = !keys.valid || keys.ready;

  always_comb begin
    state_next = state;
    case (state)
      rkd_pkg::S_IDLE: begin
        if (primes.valid) state_next = rkd_pkg::S_SETUP;
      end
      rkd_pkg::S_SETUP: state_next = rkd_pkg::S_CHECK;
      rkd_pkg::S_CHECK: begin
        if (bad || phi < W'(2)) begin
          state_next = rkd_pkg::S_FINISH;
        end else begin
          state_next = rkd_pkg::S_GCD;
        end
      end
      rkd_pkg::S_GCD: begin
        if (y != '0) begin
          state_next = rkd_pkg::S_GCD_WAIT;
        end else if (x == W'(1)) begin
          state_next = rkd_pkg::S_EMOD;
        end
      end
      rkd_pkg::S_GCD_WAIT: begin
        if (mrsp.done) state_next = rkd_pkg::S_GCD;
      end
      rkd_pkg::S_EMOD: state_next = rkd_pkg::S_EMOD_WAIT;
      rkd_pkg::S_EMOD_WAIT: begin
        if (mrsp.done) state_next = rkd_pkg::S_DSTEP;
      end
      rkd_pkg::S_DSTEP: begin
        if (r_next == W'(1)) state_next = rkd_pkg::S_FINISH;
      end
      rkd_pkg::S_FINISH: begin
        if (out_free) state_next = rkd_pkg::S_IDLE;
      end
      default: state_next = rkd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    primes.ready  = 1'b0;
    mreq.start    = 1'b0;
    mreq.dividend = x;
    mreq.divisor  = y;
    case (state)
      rkd_pkg::S_IDLE: primes.ready = !rst;
      rkd_pkg::S_GCD: mreq.start = (y != '0);
      rkd_pkg::S_EMOD: begin
        mreq.start    = 1'b1;
        mreq.dividend = e;
        mreq.divisor  = phi;
      end
      default: begin
        primes.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rkd_pkg::S_IDLE;
      keys.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rkd_pkg::S_FINISH && out_free) begin
        keys.valid <= 1'b1;
      end else if (keys.valid && keys.ready) begin
        keys.valid <= 1'b0;
      end
      case (state)
        rkd_pkg::S_IDLE: begin
          p <= primes.prime_p;
          q <= primes.prime_q;
        end
        rkd_pkg::S_SETUP: begin
          n   <= {{(W-P){1'b0}}, p} * {{(W-P){1'b0}}, q};
          phi <= ({{(W-P){1'b0}}, p} - W'(1)) * ({{(W-P){1'b0}}, q} - W'(1));
          bad <= (p == '0) || (q == '0) ||
                 ({1'b0, p} >= (P+1)'(PRIME_LIMIT)) ||
                 ({1'b0, q} >= (P+1)'(PRIME_LIMIT));
        end
        rkd_pkg::S_CHECK: begin
          if (bad || phi < W'(2)) begin
            bad <= 1'b1;
            e   <= '0;
            d   <= '0;
          end else begin
            e <= W'(2);
            x <= W'(2);
            y <= phi;
          end
        end
        rkd_pkg::S_GCD: begin
          if (y == '0 && x != W'(1)) begin
            e <= e + 1'b1;
            x <= e + 1'b1;
            y <= phi;
          end
        end
        rkd_pkg::S_GCD_WAIT: begin
          if (mrsp.done) begin
            x <= y;
            y <= mrsp.rem;
          end
        end
        rkd_pkg::S_EMOD_WAIT: begin
          if (mrsp.done) begin
            em <= mrsp.rem;
            r  <= mrsp.rem;
            d  <= W'(1);
          end
        end
        rkd_pkg::S_DSTEP: begin
          d <= d + 1'b1;
          r <= r_next;
        end
        rkd_pkg::S_FINISH: begin
          if (out_free) begin
            keys.modulus     <= n;
            keys.public_exp  <= e;
            keys.private_exp <= d;
            keys.bad_input   <= bad;
          end
        end
        default: begin
          bad <= bad;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rsa_key_derivation_top: drives prime pairs, predicts each key word.
// Depends on rkd_pkg, the rkd_in_if / rkd_out_if channels and the top level.
module tb;

  typedef struct packed {
    logic [rkd_pkg::WORD_W-1:0] modulus;
    logic [rkd_pkg::WORD_W-1:0] public_exp;
    logic [rkd_pkg::WORD_W-1:0] private_exp;
    logic                       bad_input;
  } key_word_t;

  typedef struct {
    logic [rkd_pkg::PRIME_W-1:0] p;
    logic [rkd_pkg::PRIME_W-1:0] q;
    key_word_t                   key;
  } owed_key_t;

  typedef struct {
    logic [rkd_pkg::PRIME_W-1:0] p;
    logic [rkd_pkg::PRIME_W-1:0] q;
    bit                          typed;
    key_word_t                   key;
  } stim_row_t;

  localparam int RANDOM_PER_PHASE = 20;
  localparam int BIG_RANDOM_MAX   = 6;
  localparam int SMALL_PRIME_TOP  = 10;

  logic clk;
  logic rst;
  int   mismatches;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   big_left;

  owed_key_t owed_keys[$];
  stim_row_t directed_rows[$];

  int unsigned prime_tab[54] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
    73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151, 157,
    163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227, 229, 233, 239, 241, 251
  };

  int phase_idle[4]  = '{0, 49, 0, 38};
  int phase_stall[4] = '{0, 0, 49, 38};

  rkd_in_if  primes_ch ();
  rkd_out_if keys_ch ();

  rsa_key_derivation_top dut (
    .clk    (clk),
    .rst    (rst),
    .primes (primes_ch),
    .keys   (keys_ch)
  );

  function automatic key_word_t derive_key(logic [rkd_pkg::PRIME_W-1:0] p,
                                           logic [rkd_pkg::PRIME_W-1:0] q);
    key_word_t   k;
    int          phi;
    int unsigned e;
    int unsigned d;
    int unsigned a;
    int unsigned b;
    int unsigned r;
    phi = (int'(p) - 1) * (int'(q) - 1);
    k.modulus     = {8'd0, p} * {8'd0, q};
    k.public_exp  = '0;
    k.private_exp = '0;
    k.bad_input   = 1'b1;
    if (phi >= 2 && int'(p) < rkd_pkg::PRIME_LIMIT_DEF &&
        int'(q) < rkd_pkg::PRIME_LIMIT_DEF) begin
      e = 1;
      do begin
        e++;
        a = e;
        b = phi;
        while (b != 0) begin
          r = a % b;
          a = b;
          b = r;
        end
      end while (a != 1);
      d = 2;
      while ((d * e) % phi != 1) d++;
      k.public_exp  = e[rkd_pkg::WORD_W-1:0];
      k.private_exp = d[rkd_pkg::WORD_W-1:0];
      k.bad_input   = 1'b0;
    end
    return k;
  endfunction

  task automatic add_row(input logic [rkd_pkg::PRIME_W-1:0] p,
                         input logic [rkd_pkg::PRIME_W-1:0] q,
                         input bit typed, input int m, input int e, input int d, input bit bad);
    stim_row_t row;
    row.p     = p;
    row.q     = q;
    row.typed = typed;
    row.key   = '{m[rkd_pkg::WORD_W-1:0], e[rkd_pkg::WORD_W-1:0],
                  d[rkd_pkg::WORD_W-1:0], bad};
    directed_rows.push_back(row);
  endtask

  task automatic send_pair(input logic [rkd_pkg::PRIME_W-1:0] p,
                           input logic [rkd_pkg::PRIME_W-1:0] q,
                           input bit typed, input key_word_t want);
    owed_key_t owed;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      primes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    primes_ch.valid   <= 1'b1;
    primes_ch.prime_p <= p;
    primes_ch.prime_q <= q;
    @(posedge clk);
    while (!primes_ch.ready) @(posedge clk);
    owed.p   = p;
    owed.q   = q;
    owed.key = typed ? want : derive_key(p, q);
    owed_keys.push_back(owed);
  endtask

  task automatic drain_keys();
    primes_ch.valid <= 1'b0;
    while (owed_keys.size() != 0) @(posedge clk);
  endtask

  function automatic void check_key_word();
    owed_key_t owed;
    key_word_t got;
    got = '{keys_ch.modulus, keys_ch.public_exp, keys_ch.private_exp, keys_ch.bad_input};
    if (owed_keys.size() == 0) begin
      $display("%0t: key word with none expected: actual %h", $time, got);
      mismatches++;
      return;
    end
    owed = owed_keys.pop_front();
    if (got.modulus !== owed.key.modulus) begin
      $display("%0t: p=%0d q=%0d modulus expected %0d actual %0d",
               $time, owed.p, owed.q, owed.key.modulus, got.modulus);
      mismatches++;
    end
    if (got.public_exp !== owed.key.public_exp) begin
      $display("%0t: p=%0d q=%0d public_exp expected %0d actual %0d",
               $time, owed.p, owed.q, owed.key.public_exp, got.public_exp);
      mismatches++;
    end
    if (got.private_exp !== owed.key.private_exp) begin
      $display("%0t: p=%0d q=%0d private_exp expected %0d actual %0d",
               $time, owed.p, owed.q, owed.key.private_exp, got.private_exp);
      mismatches++;
    end
    if (got.bad_input !== owed.key.bad_input) begin
      $display("%0t: p=%0d q=%0d bad_input expected %0d actual %0d",
               $time, owed.p, owed.q, owed.key.bad_input, got.bad_input);
      mismatches++;
    end
  endfunction

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && keys_ch.valid && keys_ch.ready) check_key_word();
    keys_ch.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int                          roll;
    int                          i;
    int                          j;
    logic [rkd_pkg::PRIME_W-1:0] p;
    logic [rkd_pkg::PRIME_W-1:0] q;
    key_word_t                   none;
    rst               <= 1'b1;
    mismatches        = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    big_left          = BIG_RANDOM_MAX;
    none              = '0;
    primes_ch.valid   <= 1'b0;
    primes_ch.prime_p <= '0;
    primes_ch.prime_q <= '0;

    // A zero prime or a phi below two gives the error flag with the modulus still formed.
    add_row(8'd0, 8'd0, 1, 0, 0, 0, 1);
    add_row(8'd1, 8'd1, 1, 1, 0, 0, 1);
    add_row(8'd0, 8'd255, 1, 0, 0, 0, 1);
    add_row(8'd255, 8'd0, 1, 0, 0, 0, 1);
    add_row(8'd2, 8'd2, 1, 4, 0, 0, 1);
    add_row(8'd1, 8'd200, 1, 200, 0, 0, 1);
    add_row(8'd255, 8'd1, 1, 255, 0, 0, 1);
    // With phi equal to two, e is one modulo phi and d becomes phi plus one.
    add_row(8'd2, 8'd3, 1, 6, 3, 3, 0);
    add_row(8'd3, 8'd2, 1, 6, 3, 3, 0);
    add_row(8'd3, 8'd3, 0, 0, 0, 0, 0);
    add_row(8'd5, 8'd7, 0, 0, 0, 0, 0);
    add_row(8'd2, 8'd255, 0, 0, 0, 0, 0);
    add_row(8'd128, 8'd2, 0, 0, 0, 0, 0);
    add_row(8'd4, 8'd4, 0, 0, 0, 0, 0);
    add_row(8'd4, 8'd2, 0, 0, 0, 0, 0);
    add_row(8'd9, 8'd15, 0, 0, 0, 0, 0);
    add_row(8'd17, 8'd19, 0, 0, 0, 0, 0);
    add_row(8'd170, 8'd85, 0, 0, 0, 0, 0);
    add_row(8'd251, 8'd241, 0, 0, 0, 0, 0);
    add_row(8'd255, 8'd255, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k])
      send_pair(directed_rows[k].p, directed_rows[k].q, directed_rows[k].typed,
                directed_rows[k].key);

    for (int ph = 0; ph < 4; ph++) begin
      drain_keys();
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 70 || (roll >= 85 && roll < 92 && big_left == 0)) begin
          i = $urandom_range(0, SMALL_PRIME_TOP);
          do j = $urandom_range(0, SMALL_PRIME_TOP); while (j == i);
          p = prime_tab[i][rkd_pkg::PRIME_W-1:0];
          q = prime_tab[j][rkd_pkg::PRIME_W-1:0];
        end else if (roll < 85) begin
          p = rkd_pkg::PRIME_W'($urandom_range(0, 40));
          q = rkd_pkg::PRIME_W'($urandom_range(0, 40));
        end else if (roll < 92) begin
          big_left--;
          i = $urandom_range(0, 53);
          do j = $urandom_range(0, 53); while (j == i);
          p = prime_tab[i][rkd_pkg::PRIME_W-1:0];
          q = prime_tab[j][rkd_pkg::PRIME_W-1:0];
        end else begin
          i = $urandom_range(0, SMALL_PRIME_TOP);
          p = prime_tab[i][rkd_pkg::PRIME_W-1:0];
          q = p;
        end
        send_pair(p, q, 0, none);
      end
    end

    drain_keys();
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== rsa_key_derivation_top.f =====
rtl/rkd_pkg.sv
rtl/rkd_ifs.sv
rtl/rkd_mod_unit.sv
rtl/rsa_key_derivation_top.sv
sim/tb.sv
